@@ design/radtan_point_undistort_assert.svh @@
// Assertion macros for the point undistortion block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef RADTAN_POINT_UNDISTORT_ASSERT_SVH
`define RADTAN_POINT_UNDISTORT_ASSERT_SVH

// Same-cycle implication.
`define RPU_ASSERT_NOW(lbl, cond, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error("rpu assertion failed");

// Next-cycle implication.
`define RPU_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error("rpu assertion failed");

`endif

@@ design/rpu_pkg.sv @@
// Shared types, constants and fixed-point helpers for the undistortion block.
// No dependencies.
package rpu_pkg;

  localparam int unsigned QBITS         = 28;
  localparam int unsigned ITERATIONS_DEF = 8;
  localparam int unsigned DIV_STEPS     = 31;
  localparam int unsigned DIV_PER_STAGE = 2;
  localparam int unsigned CFG_IDX_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TANGENT_P1 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TANGENT_P2 = 4'd7;

  localparam logic [27:0] FOCAL_RST    = 28'd33554432;
  localparam logic [27:0] CENTER_X_RST = 28'd20971520;
  localparam logic [27:0] CENTER_Y_RST = 28'd15728640;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t k1;
    q_t k2;
    q_t p1;
    q_t p2;
  } coef_t;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t xd;
    q_t yd;
  } est_t;

  function automatic q_t sat_q(input logic signed [37:0] v);
    q_t r;
    if (v[37:31] == {7{v[37]}}) begin
      r = v[31:0];
    end else if (v[37]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7fffffff;
    end
    return r;
  endfunction

  function automatic q_t add_q(input q_t a, input q_t b);
    return sat_q(38'(a) + 38'(b));
  endfunction

  function automatic q_t mul_q(input q_t a, input q_t b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = 64'(a) * 64'(b) + 64'sd134217728;
    s = p >>> QBITS;
    return sat_q(s[37:0]);
  endfunction

endpackage

@@ design/radtan_point_undistort.sv @@
// Throughput: one transaction per cycle; the divider and each undistortion
// step are fully pipelined, and the whole pipeline holds while the output stalls.
// Reset: asynchronous, active low; clears all valid bits and loads the
// default focal lengths, principal point and zero distortion coefficients.
// Top level: configuration registers, normalisation front end, step chain.
module radtan_point_undistort #(
  parameter int unsigned ITERATIONS = rpu_pkg::ITERATIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pixel_valid_i,
  output logic        pixel_stall_o,
  input  logic [15:0] pixel_x_i,
  input  logic [15:0] pixel_y_i,
  output logic        undist_valid_o,
  input  logic        undist_stall_i,
  output logic signed [31:0] undist_x_o,
  output logic signed [31:0] undist_y_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [rpu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [27:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  rpu_pkg::coef_t coef_q;
  logic en;
  logic [ITERATIONS:0] vld;
  rpu_pkg::est_t est [ITERATIONS+1];

  assign cfg_ready_o   = 1'b1;
  assign en            = !(undist_valid_o && undist_stall_i);
  assign pixel_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= rpu_pkg::FOCAL_RST;
      focal_y_q  <= rpu_pkg::FOCAL_RST;
      center_x_q <= rpu_pkg::CENTER_X_RST;
      center_y_q <= rpu_pkg::CENTER_Y_RST;
      coef_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rpu_pkg::REG_FOCAL_X:    focal_x_q  <= cfg_data_i[27:0];
        rpu_pkg::REG_FOCAL_Y:    focal_y_q  <= cfg_data_i[27:0];
        rpu_pkg::REG_CENTER_X:   center_x_q <= cfg_data_i[27:0];
        rpu_pkg::REG_CENTER_Y:   center_y_q <= cfg_data_i[27:0];
        rpu_pkg::REG_RADIAL_K1:  coef_q.k1  <= cfg_data_i;
        rpu_pkg::REG_RADIAL_K2:  coef_q.k2  <= cfg_data_i;
        rpu_pkg::REG_TANGENT_P1: coef_q.p1  <= cfg_data_i;
        rpu_pkg::REG_TANGENT_P2: coef_q.p2  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rpu_norm u_norm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (pixel_valid_i),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .focal_x_i  (focal_x_q),
    .focal_y_i  (focal_y_q),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .valid_o    (vld[0]),
    .est_o      (est[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    rpu_iter u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[i]),
      .est_i   (est[i]),
      .coef_i  (coef_q),
      .valid_o (vld[i+1]),
      .est_o   (est[i+1])
    );
  end

  assign undist_valid_o = vld[ITERATIONS];
  assign undist_x_o     = est[ITERATIONS].x;
  assign undist_y_o     = est[ITERATIONS].y;

`include "radtan_point_undistort_assert.svh"

  `RPU_ASSERT_NEXT(a_hold_valid, !en, $stable(vld))
  `RPU_ASSERT_NEXT(a_focal_wr, cfg_valid_i && cfg_index_i == rpu_pkg::REG_FOCAL_X,
                   focal_x_q == $past(cfg_data_i[27:0]))
  `RPU_ASSERT_NOW(a_stall_src, pixel_stall_o, undist_valid_o && undist_stall_i)

endmodule

@@ design/rpu_norm.sv @@
// Normalisation front end: offset by the principal point, then a pipelined
// restoring divider by the focal length for both axes. Depends on rpu_pkg.
module rpu_norm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [15:0] pixel_x_i,
  input  logic [15:0] pixel_y_i,
  input  logic [27:0] focal_x_i,
  input  logic [27:0] focal_y_i,
  input  logic [27:0] center_x_i,
  input  logic [27:0] center_y_i,
  output logic        valid_o,
  output rpu_pkg::est_t est_o
);

  localparam int unsigned NST =
    (rpu_pkg::DIV_STEPS + rpu_pkg::DIV_PER_STAGE - 1) / rpu_pkg::DIV_PER_STAGE;

  logic [27:0] dvs [2];
  logic [15:0] pix [2];
  logic [27:0] ctr [2];

  logic [NST:0] vld_q;
  logic [27:0]  rem_q  [NST+1][2];
  logic [30:0]  quo_q  [NST+1][2];
  logic [30:0]  feed_q [NST+1][2];
  logic         neg_q  [NST+1][2];
  logic         ovf_q  [NST+1][2];

  logic [27:0]  rem_d  [NST+1][2];
  logic [30:0]  quo_d  [NST+1][2];
  logic [30:0]  feed_d [NST+1][2];
  logic         neg_d  [NST+1][2];
  logic         ovf_d  [NST+1][2];

  rpu_pkg::q_t res [2];

  assign pix[0] = pixel_x_i;
  assign pix[1] = pixel_y_i;
  assign ctr[0] = center_x_i;
  assign ctr[1] = center_y_i;
  assign dvs[0] = (focal_x_i == '0) ? 28'd1 : focal_x_i;
  assign dvs[1] = (focal_y_i == '0) ? 28'd1 : focal_y_i;

  always_comb begin
    logic signed [28:0] diff;
    logic [28:0] mag;
    for (int a = 0; a < 2; a++) begin
      diff = $signed({1'b0, pix[a], 12'b0}) - $signed({1'b0, ctr[a]});
      mag = diff[28] ? 29'(-diff) : 29'(diff);
      neg_d[0][a]  = diff[28];
      ovf_d[0][a]  = {2'b0, mag} >= {dvs[a], 3'b0};
      rem_d[0][a]  = {2'b0, mag[28:3]};
      feed_d[0][a] = {mag[2:0], 28'b0};
      quo_d[0][a]  = '0;
    end
  end

  for (genvar g = 1; g <= NST; g++) begin : g_stage
    always_comb begin
      logic [27:0] r;
      logic [30:0] q;
      logic [30:0] f;
      logic [28:0] t;
      for (int a = 0; a < 2; a++) begin
        r = rem_q[g-1][a];
        q = quo_q[g-1][a];
        f = feed_q[g-1][a];
        for (int j = 0; j < rpu_pkg::DIV_PER_STAGE; j++) begin
          if ((g - 1) * rpu_pkg::DIV_PER_STAGE + j < rpu_pkg::DIV_STEPS) begin
            t = {r, f[30]};
            f = {f[29:0], 1'b0};
            if (t >= {1'b0, dvs[a]}) begin
              r = 28'(t - {1'b0, dvs[a]});
              q = {q[29:0], 1'b1};
            end else begin
              r = t[27:0];
              q = {q[29:0], 1'b0};
            end
          end
        end
        rem_d[g][a]  = r;
        quo_d[g][a]  = q;
        feed_d[g][a] = f;
        neg_d[g][a]  = neg_q[g-1][a];
        ovf_d[g][a]  = ovf_q[g-1][a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s <= NST; s++) begin
        for (int a = 0; a < 2; a++) begin
          rem_q[s][a]  <= rem_d[s][a];
          quo_q[s][a]  <= quo_d[s][a];
          feed_q[s][a] <= feed_d[s][a];
          neg_q[s][a]  <= neg_d[s][a];
          ovf_q[s][a]  <= ovf_d[s][a];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (ovf_q[NST][a]) begin
        res[a] = neg_q[NST][a] ? 32'sh80000000 : 32'sh7fffffff;
      end else if (neg_q[NST][a]) begin
        res[a] = -$signed({1'b0, quo_q[NST][a]});
      end else begin
        res[a] = $signed({1'b0, quo_q[NST][a]});
      end
    end
  end

  assign valid_o  = vld_q[NST];
  assign est_o.x  = res[0];
  assign est_o.y  = res[1];
  assign est_o.xd = res[0];
  assign est_o.yd = res[1];

endmodule

@@ design/rpu_iter.sv @@
// One fixed-point undistortion step as a seven-stage pipeline.
// Depends on rpu_pkg for the estimate type and saturating arithmetic.
module rpu_iter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rpu_pkg::est_t est_i,
  input  rpu_pkg::coef_t coef_i,
  output logic          valid_o,
  output rpu_pkg::est_t est_o
);

  logic [6:0] vld_q;
  rpu_pkg::est_t e1_q, e2_q, e3_q, e4_q, e5_q, e6_q, e7_q;
  rpu_pkg::q_t x2_1_q, y2_1_q, xy_1_q;
  rpu_pkg::q_t x2_2_q, y2_2_q, r2_2_q, pa_2_q, pb_2_q;
  rpu_pkg::q_t r4_3_q, kr2_3_q, tx_3_q, ty_3_q, pa_3_q, pb_3_q;
  rpu_pkg::q_t kr2_4_q, kr4_4_q, ptx_4_q, pty_4_q, pa_4_q, pb_4_q;
  rpu_pkg::q_t rad_5_q, ptx_5_q, pty_5_q, pa_5_q, pb_5_q;
  rpu_pkg::q_t xr_6_q, yr_6_q, ptx_6_q, pty_6_q, pa_6_q, pb_6_q;
  rpu_pkg::q_t dx, dy;
  rpu_pkg::est_t e7_d;

  always_comb begin
    dx = rpu_pkg::sat_q(38'(xr_6_q) + (38'(pa_6_q) <<< 1) + 38'(ptx_6_q));
    dy = rpu_pkg::sat_q(38'(yr_6_q) + (38'(pb_6_q) <<< 1) + 38'(pty_6_q));
    e7_d    = e6_q;
    e7_d.x  = rpu_pkg::sat_q(38'(e6_q.xd) - 38'(dx));
    e7_d.y  = rpu_pkg::sat_q(38'(e6_q.yd) - 38'(dy));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q    <= est_i;
      x2_1_q  <= rpu_pkg::mul_q(est_i.x, est_i.x);
      y2_1_q  <= rpu_pkg::mul_q(est_i.y, est_i.y);
      xy_1_q  <= rpu_pkg::mul_q(est_i.x, est_i.y);

      e2_q    <= e1_q;
      x2_2_q  <= x2_1_q;
      y2_2_q  <= y2_1_q;
      r2_2_q  <= rpu_pkg::add_q(x2_1_q, y2_1_q);
      pa_2_q  <= rpu_pkg::mul_q(coef_i.p1, xy_1_q);
      pb_2_q  <= rpu_pkg::mul_q(coef_i.p2, xy_1_q);

      e3_q    <= e2_q;
      r4_3_q  <= rpu_pkg::mul_q(r2_2_q, r2_2_q);
      kr2_3_q <= rpu_pkg::mul_q(coef_i.k1, r2_2_q);
      tx_3_q  <= rpu_pkg::sat_q(38'(r2_2_q) + (38'(x2_2_q) <<< 1));
      ty_3_q  <= rpu_pkg::sat_q(38'(r2_2_q) + (38'(y2_2_q) <<< 1));
      pa_3_q  <= pa_2_q;
      pb_3_q  <= pb_2_q;

      e4_q    <= e3_q;
      kr2_4_q <= kr2_3_q;
      kr4_4_q <= rpu_pkg::mul_q(coef_i.k2, r4_3_q);
      ptx_4_q <= rpu_pkg::mul_q(coef_i.p2, tx_3_q);
      pty_4_q <= rpu_pkg::mul_q(coef_i.p1, ty_3_q);
      pa_4_q  <= pa_3_q;
      pb_4_q  <= pb_3_q;

      e5_q    <= e4_q;
      rad_5_q <= rpu_pkg::add_q(kr2_4_q, kr4_4_q);
      ptx_5_q <= ptx_4_q;
      pty_5_q <= pty_4_q;
      pa_5_q  <= pa_4_q;
      pb_5_q  <= pb_4_q;

      e6_q    <= e5_q;
      xr_6_q  <= rpu_pkg::mul_q(e5_q.x, rad_5_q);
      yr_6_q  <= rpu_pkg::mul_q(e5_q.y, rad_5_q);
      ptx_6_q <= ptx_5_q;
      pty_6_q <= pty_5_q;
      pa_6_q  <= pa_5_q;
      pb_6_q  <= pb_5_q;

      e7_q    <= e7_d;
    end
  end

  assign valid_o = vld_q[6];
  assign est_o   = e7_q;

endmodule
